// ===== hdl/skf_pkg.sv =====
// Package for the scalar Kalman estimator: payload words, register
// indexes, datapath operation codes and fixed widths. No dependencies.
package skf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EST_W         = 32;
  localparam int VAR_W         = 32;
  localparam int NOISE_W       = 24;
  localparam int DT_W          = 16;
  localparam int GAIN_W        = 17;
  localparam int GAIN_FRAC     = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  typedef struct packed {
    logic                    action;
    logic signed [EST_W-1:0] rate_in;
    logic signed [EST_W-1:0] measured;
    logic [DT_W-1:0]         sample_period;
  } in_word_t;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [VAR_W-1:0]        variance;
    logic [GAIN_W-1:0]       gain;
    logic                    saturated;
  } out_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_EST   = 2'd0,
    CFG_INIT_VAR   = 2'd1,
    CFG_RATE_NOISE = 2'd2,
    CFG_MEAS_NOISE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_P5,
    OP_P6,
    OP_P7,
    OP_DIV,
    OP_GAIN,
    OP_C1,
    OP_C2,
    OP_C3
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

// ===== hdl/skf_ctrl.sv =====
// Sequencer for the scalar Kalman estimator: steps the datapath through
// predict, divide and correct, or loads the initial state on a restart,
// and owns the input and output handshakes. Depends on skf_pkg.
module skf_ctrl
  import skf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_LOAD = 16'h0002,
    S_P1   = 16'h0004,
    S_P2   = 16'h0008,
    S_P3   = 16'h0010,
    S_P4   = 16'h0020,
    S_P5   = 16'h0040,
    S_P6   = 16'h0080,
    S_P7   = 16'h0100,
    S_DIV  = 16'h0200,
    S_GAIN = 16'h0400,
    S_C1   = 16'h0800,
    S_C2   = 16'h1000,
    S_C3   = 16'h2000,
    S_OUT  = 16'h4000,
    S_SPARE = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.capture  = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = restart ? S_LOAD : S_P1;
        end
      end
      S_LOAD: begin cmd.op = OP_LOAD; state_next = S_OUT; end
      S_P1:   begin cmd.op = OP_P1;   state_next = S_P2;  end
      S_P2:   begin cmd.op = OP_P2;   state_next = S_P3;  end
      S_P3:   begin cmd.op = OP_P3;   state_next = S_P4;  end
      S_P4:   begin cmd.op = OP_P4;   state_next = S_P5;  end
      S_P5:   begin cmd.op = OP_P5;   state_next = S_P6;  end
      S_P6:   begin cmd.op = OP_P6;   state_next = S_P7;  end
      S_P7:   begin cmd.op = OP_P7;   state_next = S_DIV; end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (status.div_last) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin cmd.op = OP_GAIN; state_next = S_C1; end
      S_C1:   begin cmd.op = OP_C1;   state_next = S_C2; end
      S_C2:   begin cmd.op = OP_C2;   state_next = S_C3; end
      S_C3:   begin cmd.op = OP_C3;   state_next = S_OUT; end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/skf_datapath.sv =====
// Datapath for the scalar Kalman estimator: configuration registers, state,
// one shared multiplier, a one-bit-a-cycle restoring divider and the output word.
// Depends on skf_pkg.
module skf_datapath
  import skf_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  in_word_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_word_t             out_data
);

  localparam int MA_W   = EST_W + 2;
  localparam int MB_W   = NOISE_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int R16_W  = PROD_W + 1 - GAIN_FRAC;
  localparam int RF_W   = PROD_W + 1 - FRACTION_BITS;
  localparam int ESUM_W = R16_W + 1;
  localparam int WIDE_W = 2 * NOISE_W - FRACTION_BITS + 1;
  localparam int DEN_W  = ((WIDE_W > VAR_W) ? WIDE_W : VAR_W) + 1;
  localparam int NUM_W  = VAR_W + GAIN_FRAC + 1;
  localparam int CNT_W  = $clog2(GAIN_W);
  localparam int INNOV_W = EST_W + 1;

  logic signed [EST_W-1:0]  init_est;
  logic [VAR_W-1:0]         init_var;
  logic [NOISE_W-1:0]       rate_noise;
  logic [NOISE_W-1:0]       meas_noise;

  logic signed [EST_W-1:0]  estimate_reg;
  logic [VAR_W-1:0]         variance_reg;
  in_word_t                 in_r;
  logic signed [EST_W-1:0]  est1;
  logic [NOISE_W-1:0]       s_r;
  logic [WIDE_W-1:0]        m2;
  logic [VAR_W-1:0]         v1;
  logic [DEN_W-1:0]         den;
  logic signed [INNOV_W-1:0] innov;
  logic [DEN_W-1:0]         rem;
  logic [GAIN_W-1:0]        numlo;
  logic [GAIN_W-1:0]        quo;
  logic [CNT_W-1:0]         cnt;
  logic [GAIN_W-1:0]        gain_r;
  logic                     sat;
  logic signed [PROD_W-1:0] prod;
  out_word_t                out_r;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     mul_en;
  logic signed [PROD_W:0]   prod_b16;
  logic signed [PROD_W:0]   prod_bf;
  logic signed [R16_W-1:0]  r16;
  logic [RF_W-1:0]          rf;
  logic signed [ESUM_W-1:0] est_sum;
  logic [EST_W:0]           est_clamp;
  logic [DEN_W-1:0]         var_sum;
  logic [NUM_W-1:0]         num;
  logic [DEN_W:0]           rem2;
  logic                     rem_ge;
  logic [GAIN_W:0]          one_minus_g;

  function automatic logic [EST_W:0] clamp_est(input logic signed [ESUM_W-1:0] v);
    logic fits;
    fits = (v[ESUM_W-1:EST_W-1] == '0) || (v[ESUM_W-1:EST_W-1] == '1);
    if (fits) begin
      clamp_est = {1'b0, v[EST_W-1:0]};
    end else if (v[ESUM_W-1]) begin
      clamp_est = {1'b1, 1'b1, {(EST_W-1){1'b0}}};
    end else begin
      clamp_est = {1'b1, 1'b0, {(EST_W-1){1'b1}}};
    end
  endfunction

  assign prod_b16    = {prod[PROD_W-1], prod} + ((PROD_W+1)'(1) << (GAIN_FRAC - 1));
  assign prod_bf     = {prod[PROD_W-1], prod} + ((PROD_W+1)'(1) << (FRACTION_BITS - 1));
  assign r16         = prod_b16[PROD_W:GAIN_FRAC];
  assign rf          = prod_bf[PROD_W:FRACTION_BITS];
  assign one_minus_g = (GAIN_W+1)'(GAIN_ONE) - (GAIN_W+1)'(gain_r);
  assign var_sum     = DEN_W'(variance_reg) + DEN_W'(rf[WIDE_W-1:0]);
  assign num         = NUM_W'({v1, {GAIN_FRAC{1'b0}}}) + NUM_W'(den >> 1);
  assign rem2        = {rem, numlo[GAIN_W-1]};
  assign rem_ge      = rem2 >= (DEN_W+1)'(den);
  assign status.div_last = (cnt == '0);

  always_comb begin
    est_sum = ESUM_W'(estimate_reg) + ESUM_W'(r16);
    if (cmd.op == OP_C2) begin
      est_sum = ESUM_W'(est1) + ESUM_W'(r16);
    end
  end

  assign est_clamp = clamp_est(est_sum);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_P1: begin
        mul_a = MA_W'(in_r.rate_in);
        mul_b = MB_W'(in_r.sample_period);
      end
      OP_P2: begin
        mul_a = MA_W'(rate_noise);
        mul_b = MB_W'(in_r.sample_period);
      end
      OP_P3: begin
        mul_a = MA_W'(meas_noise);
        mul_b = MB_W'(meas_noise);
      end
      OP_P4: begin
        mul_a = MA_W'(s_r);
        mul_b = MB_W'(s_r);
      end
      OP_C1: begin
        mul_a = MA_W'(innov);
        mul_b = MB_W'(gain_r);
      end
      OP_C2: begin
        mul_a = MA_W'(v1);
        mul_b = MB_W'(one_minus_g);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_est   <= '0;
      init_var   <= '0;
      rate_noise <= NOISE_W'(262144);
      meas_noise <= NOISE_W'(196608);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INIT_EST:   init_est   <= cfg_data[EST_W-1:0];
        CFG_INIT_VAR:   init_var   <= cfg_data[VAR_W-1:0];
        CFG_RATE_NOISE: rate_noise <= cfg_data[NOISE_W-1:0];
        CFG_MEAS_NOISE: meas_noise <= cfg_data[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg <= '0;
      variance_reg <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          estimate_reg <= init_est;
          variance_reg <= init_var;
        end
        OP_C2: estimate_reg <= est_clamp[EST_W-1:0];
        OP_C3: begin
          if (r16[R16_W-1:VAR_W] != '0) begin
            variance_reg <= '1;
          end else begin
            variance_reg <= r16[VAR_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.capture) begin
      in_r <= in_data;
      sat  <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r.estimate  <= estimate_reg;
      out_r.variance  <= variance_reg;
      out_r.gain      <= gain_r;
      out_r.saturated <= sat;
    end
    case (cmd.op)
      OP_LOAD: begin
        gain_r <= '0;
        sat    <= 1'b0;
      end
      OP_P2: begin
        est1 <= est_clamp[EST_W-1:0];
        sat  <= est_clamp[EST_W];
      end
      OP_P3: s_r <= r16[NOISE_W-1:0];
      OP_P4: m2  <= rf[WIDE_W-1:0];
      OP_P5: begin
        if (var_sum[DEN_W-1:VAR_W] != '0) begin
          v1  <= '1;
          sat <= 1'b1;
        end else begin
          v1 <= var_sum[VAR_W-1:0];
        end
      end
      OP_P6: begin
        den   <= DEN_W'(v1) + DEN_W'(m2);
        innov <= INNOV_W'(in_r.measured) - INNOV_W'(est1);
      end
      OP_P7: begin
        rem   <= DEN_W'(num[NUM_W-1:GAIN_W]);
        numlo <= num[GAIN_W-1:0];
        quo   <= '0;
        cnt   <= CNT_W'(GAIN_W - 1);
      end
      OP_DIV: begin
        if (rem_ge) begin
          rem <= DEN_W'(rem2 - (DEN_W+1)'(den));
        end else begin
          rem <= rem2[DEN_W-1:0];
        end
        numlo <= {numlo[GAIN_W-2:0], 1'b0};
        quo   <= {quo[GAIN_W-2:0], rem_ge};
        cnt   <= cnt - CNT_W'(1);
      end
      OP_GAIN: begin
        if (den == '0) begin
          gain_r <= '0;
        end else if (quo > GAIN_ONE) begin
          gain_r <= GAIN_ONE;
        end else begin
          gain_r <= quo;
        end
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

// ===== hdl/scalar_kalman_estimator_top.sv =====
// Scalar Kalman estimator, top level: joins the sequencer and the datapath.
// An update word is taken through predict, the 17-step restoring divide for
// the gain and correct before the result word is offered; a restart word
// only loads the initial state. The next word can be taken in the cycle after
// the result is loaded into the output register. Configuration writes are always ready.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
module scalar_kalman_estimator_top
  import skf_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  skf_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output word overwritten while pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in progress");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not offered");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.gain <= GAIN_ONE))
    else $error("gain above one");

endmodule

// ===== dv/scalar_kalman_estimator_top_tb.sv =====
// Testbench for scalar_kalman_estimator_top: a directed table, then randomized
// phases of words checked against a Q16.16 predictor of the estimator.
// Depends on skf_pkg and the estimator RTL.
module scalar_kalman_estimator_top_tb;
  import skf_pkg::*;

  localparam int     FRAC           = FRAC_BITS_DEF;
  localparam bit     ACT_UPDATE     = 1'b0;
  localparam bit     ACT_RESTART    = 1'b1;
  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [15:0] DT_MAX    = 16'hFFFF;
  localparam logic [NOISE_W-1:0] RATE_NOISE_RST = 24'd262144;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 24'd196608;
  localparam longint EST_MAX        = (longint'(1) <<< (EST_W - 1)) - 1;
  localparam longint EST_MIN        = -(longint'(1) <<< (EST_W - 1));
  localparam bit [63:0] VAR_MAX     = (64'd1 << VAR_W) - 1;
  localparam longint DT_HALF        = longint'(1) <<< (DT_W - 1);
  localparam longint GAIN_HALF      = longint'(1) <<< (GAIN_FRAC - 1);
  localparam longint FRAC_HALF      = longint'(1) <<< (FRAC - 1);
  localparam int     PHASES         = 10;
  localparam int     PHASE_ITEMS    = 103;
  localparam int     HOLD_PHASE     = 1;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     TAIL_CYCLES    = 64;

  typedef struct packed {
    logic                  is_cfg;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    in_word_t              w;
    logic                  typed;
    out_word_t             want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [EST_W-1:0]   cfg_init_est;
  logic [VAR_W-1:0]   cfg_init_var;
  logic [NOISE_W-1:0] cfg_rate_noise;
  logic [NOISE_W-1:0] cfg_meas_noise;
  logic signed [EST_W-1:0] est_q;
  logic [VAR_W-1:0]        var_q;

  out_word_t predicted_words[$];
  plan_row_t plan[$];
  int  mismatches     = 0;
  int  src_idle_odds  = 3;
  int  sink_idle_odds = 3;
  bit  hold_req       = 1'b0;
  bit  hold_done      = 1'b0;
  int  quiet_cycles   = 0;

  scalar_kalman_estimator_top #(.FRACTION_BITS(FRAC)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_word_t predict_kalman(in_word_t w);
    out_word_t r;
    longint rate, meas, dt_s, delta, est_sum, est1, innov, corr, g;
    bit [63:0] dt_u, s, inc, v1, m2, den, gain, v2;
    bit sat;
    sat  = 1'b0;
    gain = '0;
    if (w.action == ACT_RESTART) begin
      est_q = cfg_init_est;
      var_q = cfg_init_var;
    end else begin
      rate  = $signed(w.rate_in);
      meas  = $signed(w.measured);
      dt_s  = w.sample_period;
      dt_u  = w.sample_period;
      delta = (dt_s * rate + DT_HALF) >>> DT_W;
      est_sum = est_q;
      est_sum = est_sum + delta;
      if (est_sum > EST_MAX) begin
        est1 = EST_MAX;
        sat  = 1'b1;
      end else if (est_sum < EST_MIN) begin
        est1 = EST_MIN;
        sat  = 1'b1;
      end else begin
        est1 = est_sum;
      end
      s   = (dt_u * 64'(cfg_rate_noise) + DT_HALF) >> DT_W;
      inc = (s * s + FRAC_HALF) >> FRAC;
      v1  = 64'(var_q) + inc;
      if (v1 > VAR_MAX) begin
        v1  = VAR_MAX;
        sat = 1'b1;
      end
      m2  = (64'(cfg_meas_noise) * 64'(cfg_meas_noise) + FRAC_HALF) >> FRAC;
      den = v1 + m2;
      if (den != 0) gain = ((v1 << GAIN_FRAC) + (den >> 1)) / den;
      if (gain > 64'(GAIN_ONE)) gain = 64'(GAIN_ONE);
      innov = meas - est1;
      g     = longint'(gain);
      corr  = (innov * g + GAIN_HALF) >>> GAIN_FRAC;
      est_sum = est1 + corr;
      if (est_sum > EST_MAX) est_sum = EST_MAX;
      if (est_sum < EST_MIN) est_sum = EST_MIN;
      est_q = est_sum[EST_W-1:0];
      v2 = ((64'(GAIN_ONE) - gain) * v1 + GAIN_HALF) >> GAIN_FRAC;
      if (v2 > VAR_MAX) v2 = VAR_MAX;
      var_q = v2[VAR_W-1:0];
    end
    r.estimate  = est_q;
    r.variance  = var_q;
    r.gain      = gain[GAIN_W-1:0];
    r.saturated = sat;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic plan_row_t word_row(bit act, logic [31:0] rate, logic [31:0] meas,
                                         logic [15:0] dt);
    plan_row_t r;
    r                 = '0;
    r.w.action        = act;
    r.w.rate_in       = rate;
    r.w.measured      = meas;
    r.w.sample_period = dt;
    return r;
  endfunction

  function automatic plan_row_t typed_row(bit act, logic [31:0] rate, logic [31:0] meas,
                                          logic [15:0] dt, logic [31:0] est,
                                          logic [31:0] vr, logic [GAIN_W-1:0] gn, bit sat);
    plan_row_t r;
    r                = word_row(act, rate, meas, dt);
    r.typed          = 1'b1;
    r.want.estimate  = est;
    r.want.variance  = vr;
    r.want.gain      = gn;
    r.want.saturated = sat;
    return r;
  endfunction

  function automatic in_word_t random_word(bit restart);
    in_word_t w;
    int sv;
    w.action   = restart || ($urandom_range(0, 7) == 0);
    w.rate_in  = $urandom;
    w.measured = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      sv = $urandom_range(0, 32'h3FFFF);
      w.rate_in = sv - 32'h20000;
    end
    case ($urandom_range(0, 5))
      0: w.measured = S32_MAX;
      1: w.measured = S32_MIN;
      2, 3: begin
        sv = $urandom_range(0, 32'h7FFFF);
        w.measured = sv - 32'h40000;
      end
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: w.sample_period = '0;
      1: w.sample_period = DT_MAX;
      2, 3, 4: w.sample_period = $urandom_range(0, 16'h0800);
      default: w.sample_period = $urandom;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) report_mismatch(name, want, got);
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_want);
    out_word_t want;
    int gap;
    gap = 0;
    if (src_idle_odds != 0 && $urandom_range(0, src_idle_odds - 1) == 0)
      gap = $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    want = predict_kalman(w);
    predicted_words.push_back(typed ? typed_want : want);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INIT_EST:   cfg_init_est   = data;
      CFG_INIT_VAR:   cfg_init_var   = data;
      CFG_RATE_NOISE: cfg_rate_noise = data[NOISE_W-1:0];
      CFG_MEAS_NOISE: cfg_meas_noise = data[NOISE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sink: random stalls, plus one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_done) begin
        out_ready  <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        hold_done  = 1'b1;
      end else if (sink_idle_odds != 0 && $urandom_range(0, sink_idle_odds - 1) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_words.size() == 0) begin
        report_mismatch("unexpected result word", '0, out_data.estimate);
      end else begin
        want = predicted_words.pop_front();
        check_field("estimate", want.estimate, out_data.estimate);
        check_field("variance", want.variance, out_data.variance);
        check_field("gain", want.gain, out_data.gain);
        check_field("saturated", want.saturated, out_data.saturated);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] v0, v1, v2, v3;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cfg_init_est   = '0;
    cfg_init_var   = '0;
    cfg_rate_noise = RATE_NOISE_RST;
    cfg_meas_noise = MEAS_NOISE_RST;
    est_q = '0;
    var_q = '0;

    plan.push_back(typed_row(ACT_RESTART, 0, 0, 0, 0, 0, 0, 1'b0));
    plan.push_back(typed_row(ACT_UPDATE, S32_MAX, S32_MAX, 0, 0, 0, 0, 1'b0));
    repeat (3) plan.push_back(word_row(ACT_UPDATE, S32_MAX, S32_MAX, DT_MAX));
    repeat (3) plan.push_back(word_row(ACT_UPDATE, S32_MIN, S32_MIN, DT_MAX));
    plan.push_back(word_row(ACT_UPDATE, 0, 0, 16'd1));
    plan.push_back(cfg_row(CFG_INIT_EST, S32_MAX));
    plan.push_back(cfg_row(CFG_INIT_VAR, ALL_ONES));
    plan.push_back(typed_row(ACT_RESTART, 0, 0, 0, S32_MAX, ALL_ONES, 0, 1'b0));
    plan.push_back(word_row(ACT_UPDATE, S32_MAX, S32_MAX, DT_MAX));
    plan.push_back(cfg_row(CFG_INIT_EST, S32_MIN));
    plan.push_back(typed_row(ACT_RESTART, 0, 0, 0, S32_MIN, ALL_ONES, 0, 1'b0));
    plan.push_back(word_row(ACT_UPDATE, S32_MIN, S32_MIN, DT_MAX));
    plan.push_back(cfg_row(CFG_MEAS_NOISE, 0));
    plan.push_back(cfg_row(CFG_INIT_VAR, 32'd100));
    plan.push_back(typed_row(ACT_RESTART, 0, 0, 0, S32_MIN, 32'd100, 0, 1'b0));
    // zero noise term: full gain snaps to the measurement
    plan.push_back(typed_row(ACT_UPDATE, 32'h1234, 32'h0005_0000, 0,
                             32'h0005_0000, 0, GAIN_ONE, 1'b0));
    // zero denominator: gain drops to zero
    plan.push_back(typed_row(ACT_UPDATE, S32_MAX, S32_MIN, 0, 32'h0005_0000, 0, 0, 1'b0));
    plan.push_back(cfg_row(CFG_RATE_NOISE, ALL_ONES));
    plan.push_back(cfg_row(CFG_MEAS_NOISE, ALL_ONES));
    plan.push_back(word_row(ACT_UPDATE, 0, 0, DT_MAX));
    plan.push_back(word_row(ACT_UPDATE, S32_MAX, S32_MIN, DT_MAX));
    plan.push_back(cfg_row(CFG_INIT_EST, 0));
    plan.push_back(cfg_row(CFG_INIT_VAR, 0));
    plan.push_back(cfg_row(CFG_RATE_NOISE, 0));
    plan.push_back(cfg_row(CFG_MEAS_NOISE, 32'h0001_0000));
    plan.push_back(typed_row(ACT_RESTART, 0, 0, 0, 0, 0, 0, 1'b0));
    plan.push_back(word_row(ACT_UPDATE, 32'h0001_0000, 32'hFFFF_0000, 16'h8000));
    // restart ignores the sample fields
    plan.push_back(typed_row(ACT_RESTART, S32_MIN, S32_MAX, DT_MAX, 0, 0, 0, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      src_idle_odds  = (p < PHASES - 2 && p % 2 == 0) ? 4 : 0;
      sink_idle_odds = (p < PHASES - 2 && p % 3 != 2) ? 4 : 0;
      if (p == HOLD_PHASE) hold_req = 1'b1;
      case (p % 5)
        0: begin
          v0 = $urandom_range(0, 32'h7FFFF) - 32'h40000;
          v1 = $urandom_range(0, 32'h100000);
          v2 = RATE_NOISE_RST;
          v3 = MEAS_NOISE_RST;
        end
        1: begin
          v0 = $urandom;
          v1 = $urandom;
          v2 = $urandom;
          v3 = $urandom;
        end
        2: begin
          v0 = 0;
          v1 = 0;
          v2 = 0;
          v3 = 0;
        end
        3: begin
          v0 = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
          v1 = ALL_ONES;
          v2 = ALL_ONES;
          v3 = ALL_ONES;
        end
        default: begin
          v0 = $urandom;
          v1 = $urandom_range(0, 32'h0100_0000);
          v2 = $urandom_range(0, 32'h8_0000);
          v3 = $urandom_range(0, 32'h8_0000);
        end
      endcase
      write_reg(CFG_INIT_EST, v0);
      write_reg(CFG_INIT_VAR, v1);
      write_reg(CFG_RATE_NOISE, v2);
      write_reg(CFG_MEAS_NOISE, v3);
      send_word(random_word(1'b1), 1'b0, '0);
      for (int n = 1; n < PHASE_ITEMS; n++)
        send_word(random_word(1'b0), 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
